// ===== design/tst_pkg.sv =====
// Shared types and constants for the TDMA slot table.
`timescale 1ns / 1ps
package tst_pkg;

  // Widths of the item fields.
  localparam int unsigned OpW   = 2;
  localparam int unsigned IdW   = 16;
  localparam int unsigned SlotW = 5;

  // Packed stream data widths, rounded up to whole bytes.
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 8;

  // Identifier that marks a free slot.
  localparam logic [IdW-1:0] FreeId = 16'h0000;

  // Operation codes.
  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_DELETE = 2'd2,
    OP_LOOKUP = 2'd3
  } op_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // Capture the item and read slot 0, or clear on a clear item.
    logic step;    // Advance the scan to the next slot.
    logic apply;   // Slot hit: update the table and record its number.
    logic miss;    // Scan ended without a hit: record zero.
    logic load_out; // Move the result into the output register.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_clear; // The offered item is a clear.
    logic hit;      // The slot under test qualifies.
    logic last;     // The slot under test is the last one.
    logic out_busy; // The output register holds an item that is not taken.
  } status_t;

endpackage

// ===== design/tst_ctrl.sv =====
// Controller state machine for the TDMA slot table.
`timescale 1ns / 1ps
module tst_ctrl
  import tst_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_axis_tvalid,
  output logic    s_axis_tready,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.start = 1'b1;
          state_d     = status_i.in_clear ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.hit) begin
          cmd_o.apply = 1'b1;
          state_d     = ST_DONE;
        end else if (status_i.last) begin
          cmd_o.miss = 1'b1;
          state_d    = ST_DONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/tst_datapath.sv =====
// Datapath of the TDMA slot table: slot memory, valid bits, scan index and result.
`timescale 1ns / 1ps
module tst_datapath
  import tst_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  input  cmd_t                cmd_i,
  output status_t             status_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  logic [IdW-1:0]   mem [SLOTS];
  logic [SLOTS-1:0] valid_q;
  logic [IdW-1:0]   rdata_q;
  logic [IdxW-1:0]  idx_q;
  logic [IdxW-1:0]  rd_addr;
  op_e              op_q;
  logic [IdW-1:0]   id_q;
  logic [SlotW-1:0] res_q;
  logic [SlotW-1:0] out_slot_q;
  logic             out_valid_q;
  logic [IdW-1:0]   stored;
  logic [8:0]       slot_num;
  op_e              in_op;

  assign in_op = op_e'(s_axis_tdata[OpW-1:0]);

  // Scan state: a slot that is not valid reads as free.
  assign stored   = valid_q[idx_q] ? rdata_q : FreeId;
  assign slot_num = 9'(idx_q) + 9'd1;

  assign status_o.in_clear = (in_op == OP_CLEAR);
  assign status_o.hit      = (stored == id_q) || ((op_q == OP_ADD) && (stored == FreeId));
  assign status_o.last     = (idx_q == LastIdx);
  assign status_o.out_busy = out_valid_q && !m_axis_tready;

  // Read address runs one slot ahead of the slot under test.
  always_comb begin
    if (cmd_i.start) begin
      rd_addr = '0;
    end else if (idx_q == LastIdx) begin
      rd_addr = idx_q;
    end else begin
      rd_addr = idx_q + IdxW'(1);
    end
  end

  // Slot memory with registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && (op_q == OP_ADD)) begin
      mem[idx_q] <= id_q;
    end
    rdata_q <= mem[rd_addr];
  end

  // Valid bits: reset and clear free every slot at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.start && (in_op == OP_CLEAR)) begin
      valid_q <= '0;
    end else if (cmd_i.apply) begin
      if (op_q == OP_ADD) begin
        valid_q[idx_q] <= 1'b1;
      end else if (op_q == OP_DELETE) begin
        valid_q[idx_q] <= 1'b0;
      end
    end
  end

  // Item capture, scan index and result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= in_op;
      id_q  <= s_axis_tdata[OpW +: IdW];
      idx_q <= '0;
      res_q <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + IdxW'(1);
    end else if (cmd_i.apply) begin
      res_q <= slot_num[SlotW-1:0];
    end else if (cmd_i.miss) begin
      res_q <= '0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_slot_q <= res_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - SlotW){1'b0}}, out_slot_q};

endmodule

// ===== design/tdma_slot_table.sv =====
// Top level of the TDMA slot table.
//
//  Channel  Direction  Payload
//  s_axis   in         tdata[1:0] operation, tdata[17:2] node_id, rest zero
//  m_axis   out        tdata[4:0] slot_number, rest zero
//
// One item at a time: the item is taken in idle, then the scan tests one slot
// per cycle from slot 1 up through the registered memory read, then the done
// state loads the output register; a clear goes straight from idle to done.
// Reset frees every slot at once through per-slot valid bits.
// A stalled output holds the finished item; the next item is taken only when
// the controller is back in idle.
`timescale 1ns / 1ps
module tdma_slot_table
  import tst_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // operation, node_id
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata   // slot_number
);

  cmd_t    cmd;
  status_t status;

  // Controller.
  tst_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // Datapath.
  tst_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

// ===== test/tdma_slot_table_test.sv =====
// Self-checking testbench for the TDMA slot table, with a predictor of the slot store.
`timescale 1ns / 1ps
module tdma_slot_table_test
  import tst_pkg::*;
();

  localparam int unsigned Slots = 16;
  // Cycles the receiver holds off to back up the block.
  localparam int HoldCycles = 300;
  // Cycles without any accepted item before the run is declared hung.
  localparam int StallLimit = 2000;
  // Cycles allowed for the block to settle once nothing is outstanding.
  localparam int SettleCycles = 40;

  // One row of the directed stimulus; typed marks a hand-written expectation.
  typedef struct packed {
    op_e            op;
    logic [IdW-1:0] node_id;
    logic           typed;
    logic [SlotW-1:0] slot;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;  // operation, node_id
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;      // slot_number

  // Predicted table contents and the slot numbers still to come out.
  logic [IdW-1:0]   slot_owner [Slots];
  logic [SlotW-1:0] expected_slots [$];

  // Idling controls for the sender and the receiver.
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  bit calm = 1'b0;
  int hold_ticket = 0;
  int hold_served = 0;
  int hold_left = 0;

  // Bookkeeping.
  int mismatches = 0;
  int results_checked = 0;
  int full_adds = 0;
  int op_count [4] = '{0, 0, 0, 0};
  int idle_run = 0;

  // Directed items: reset state, node zero, a full table and a clear.
  dir_row_t dir_rows [26] = '{
    '{OP_LOOKUP, 16'h0000, 1'b1, 5'd1},   // free table: node zero finds slot 1
    '{OP_ADD,    16'hFFFF, 1'b1, 5'd1},
    '{OP_ADD,    16'hFFFF, 1'b1, 5'd1},   // node already present
    '{OP_ADD,    16'h0000, 1'b1, 5'd2},   // node zero lands on the first free slot
    '{OP_DELETE, 16'h0000, 1'b1, 5'd2},   // slot stays free
    '{OP_ADD,    16'h0001, 1'b1, 5'd2},
    '{OP_ADD,    16'h0002, 1'b0, 5'd0},
    '{OP_ADD,    16'h0004, 1'b0, 5'd0},
    '{OP_ADD,    16'h0008, 1'b0, 5'd0},
    '{OP_ADD,    16'h0010, 1'b0, 5'd0},
    '{OP_ADD,    16'h0020, 1'b0, 5'd0},
    '{OP_ADD,    16'h0040, 1'b0, 5'd0},
    '{OP_ADD,    16'h0080, 1'b0, 5'd0},
    '{OP_ADD,    16'h0100, 1'b0, 5'd0},
    '{OP_ADD,    16'h0200, 1'b0, 5'd0},
    '{OP_ADD,    16'h0400, 1'b0, 5'd0},
    '{OP_ADD,    16'h0800, 1'b0, 5'd0},
    '{OP_ADD,    16'h1000, 1'b0, 5'd0},
    '{OP_ADD,    16'h2000, 1'b0, 5'd0},
    '{OP_ADD,    16'h4000, 1'b1, 5'd16},
    '{OP_ADD,    16'h8000, 1'b1, 5'd0},   // table full
    '{OP_ADD,    16'h0000, 1'b1, 5'd0},   // no free slot for node zero
    '{OP_LOOKUP, 16'h0000, 1'b1, 5'd0},
    '{OP_DELETE, 16'hFFFF, 1'b1, 5'd1},
    '{OP_CLEAR,  16'h0000, 1'b1, 5'd0},
    '{OP_LOOKUP, 16'h0001, 1'b1, 5'd0}    // gone after the clear
  };

  tdma_slot_table #(
    .SLOTS(Slots)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Applies one operation to the predicted table and returns the slot it reports.
  function automatic logic [SlotW-1:0] predict_slot(input op_e op, input logic [IdW-1:0] id);
    int hit;
    hit = -1;
    if (op == OP_CLEAR) begin
      foreach (slot_owner[i]) slot_owner[i] = FreeId;
      return '0;
    end
    for (int i = 0; i < Slots; i++) begin
      if (hit < 0 && (slot_owner[i] == id || (op == OP_ADD && slot_owner[i] == FreeId))) begin
        hit = i;
      end
    end
    if (hit < 0) return '0;
    if (op == OP_ADD) slot_owner[hit] = id;
    else if (op == OP_DELETE) slot_owner[hit] = FreeId;
    return SlotW'(hit + 1);
  endfunction

  // Counts one mismatch and prints it while no more than 100 have been seen.
  task automatic report_mismatch(input string what, input logic [SlotW-1:0] want,
                                 input logic [SlotW-1:0] got);
    mismatches++;
    if (mismatches <= 100) begin
      $display("MISMATCH at %0t ns: %s, expected slot %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Offers one item, starting and ending at a falling edge, and records its expectation.
  task automatic offer_item(input op_e op, input logic [IdW-1:0] id, input logic typed,
                            input logic [SlotW-1:0] typed_slot);
    logic [SlotW-1:0] predicted;
    while (!calm && $urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(InDataW - OpW - IdW){1'b0}}, id, op};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_slot(op, id);
    expected_slots.push_back(typed ? typed_slot : predicted);
    op_count[op]++;
    if (op == OP_ADD && predicted == '0) full_adds++;
    @(negedge clk_i);
  endtask

  // Receiver: random stalls, calm stretches and one long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_ticket != hold_served) begin
      hold_served <= hold_ticket;
      hold_left <= HoldCycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Result checker against the oldest outstanding expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      if (expected_slots.size() == 0) begin
        report_mismatch("result with no item outstanding", '0, m_axis_tdata[SlotW-1:0]);
      end else if (m_axis_tdata[SlotW-1:0] !== expected_slots[0]) begin
        report_mismatch("slot_number", expected_slots[0], m_axis_tdata[SlotW-1:0]);
        void'(expected_slots.pop_front());
      end else begin
        void'(expected_slots.pop_front());
      end
    end
  end

  // Watchdog on cycles in which no item moves on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_run <= 0;
    end else if (idle_run >= StallLimit) begin
      $display("Timeout: no item moved for %0d cycles", StallLimit);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // Stimulus: reset, directed rows, then four idling phases of random items.
  initial begin : stimulus
    op_e            rnd_op;
    logic [IdW-1:0] rnd_id;
    int             roll;
    int             phase_items;

    foreach (slot_owner[i]) slot_owner[i] = FreeId;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      offer_item(dir_rows[r].op, dir_rows[r].node_id, dir_rows[r].typed, dir_rows[r].slot);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  phase_items = 400; end
        1: begin sender_idle_pct = 56; receiver_stall_pct = 0;  phase_items = 500; end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 56; phase_items = 500; end
        default: begin
          sender_idle_pct = 37; receiver_stall_pct = 37; phase_items = 550;
        end
      endcase
      // Back up the block behind a long output hold-off.
      if (ph == 2) hold_ticket++;
      // Let everything drain before the last phase.
      if (ph == 3) begin
        s_axis_tvalid <= 1'b0;
        while (expected_slots.size() != 0) @(negedge clk_i);
      end
      for (int n = 0; n < phase_items; n++) begin
        calm = (n % 100) < 12;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          // Noise: any operation on any identifier.
          rnd_op = op_e'($urandom_range(0, 3));
          rnd_id = IdW'($urandom);
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 2) rnd_op = OP_CLEAR;
          else if (roll < 50) rnd_op = OP_ADD;
          else if (roll < 72) rnd_op = OP_DELETE;
          else rnd_op = OP_LOOKUP;
          // A small pool of nodes so that the table fills and ids repeat.
          roll = $urandom_range(0, 99);
          if (roll < 8) rnd_id = FreeId;
          else if (roll < 88) rnd_id = IdW'($urandom_range(1, 24));
          else rnd_id = IdW'($urandom);
        end
        offer_item(rnd_op, rnd_id, 1'b0, '0);
      end
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (expected_slots.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);

    $display("Ran %0d clears, %0d adds, %0d deletes and %0d lookups; %0d results checked.",
             op_count[OP_CLEAR], op_count[OP_ADD], op_count[OP_DELETE], op_count[OP_LOOKUP],
             results_checked);
    $display("Adds refused on a full table: %0d; idling phases, a long hold-off and a drain.",
             full_adds);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
